[sv/b64c_pkg.sv]
// ----------------------------------------------------------------------------
// b64c_pkg: shared types, constants and alphabet functions
// Result and queue entry formats plus the base64 character mapping.
// ----------------------------------------------------------------------------
package b64c_pkg;

	localparam int unsigned APB_AW = 3;
	localparam int unsigned APB_DW = 32;

	localparam logic REG_DIRECTION = 1'b0;

	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	localparam logic [7:0] CHAR_PAD   = 8'd61;
	localparam logic [7:0] CHAR_PLUS  = 8'd43;
	localparam logic [7:0] CHAR_SLASH = 8'd47;
	localparam logic [7:0] UPPER_OFS  = 8'd65;
	localparam logic [7:0] LOWER_OFS  = 8'd71;
	localparam logic [5:0] SIX_PLUS   = 6'd62;
	localparam logic [5:0] SIX_SLASH  = 6'd63;

	typedef struct packed {
		logic [7:0] data;
		logic       dvalid;
		logic       last;
		logic       bad;
	} res_t;

	typedef struct packed {
		logic [1:0]     cnt_m1;
		res_t [3:0]     res;
	} job_t;

	function automatic logic [7:0] six_to_char(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v < 6'd26)
			return w + UPPER_OFS;
		else if (v < 6'd52)
			return w + LOWER_OFS;
		else if (v < SIX_PLUS)
			return w - 8'd4;
		else if (v == SIX_PLUS)
			return CHAR_PLUS;
		else
			return CHAR_SLASH;
	endfunction

	// bit 6 set: not in the alphabet
	function automatic logic [6:0] char_to_six(input logic [7:0] c);
		if (c >= 8'd65 && c <= 8'd90)
			return 7'(c - UPPER_OFS);
		else if (c >= 8'd97 && c <= 8'd122)
			return 7'(c - LOWER_OFS);
		else if (c >= 8'd48 && c <= 8'd57)
			return 7'(c + 8'd4);
		else if (c == CHAR_PLUS)
			return {1'b0, SIX_PLUS};
		else if (c == CHAR_SLASH)
			return {1'b0, SIX_SLASH};
		else
			return 7'd64;
	endfunction

endpackage

[sv/b64c_front.sv]
// ----------------------------------------------------------------------------
// b64c_front: item intake and classification
// Holds the stream state and turns each item into a job of up to four results.
// ----------------------------------------------------------------------------
module b64c_front
	import b64c_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       direction,
	input  logic       clear,
	input  logic       accept,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       push,
	output job_t       push_job
);

	logic [5:0] buf_q;
	logic [2:0] cnt_q;
	logic [1:0] phase_q;
	logic       pad_q;

	logic [5:0] buf_d;
	logic [2:0] cnt_d;
	logic [1:0] phase_d;
	logic       pad_d;
	logic [2:0] n;
	res_t [3:0] res;

	logic [11:0] enc_nb;
	logic [5:0]  enc_c0;
	logic [5:0]  enc_left;
	logic        enc_two;
	logic        enc_has_left;
	logic [1:0]  enc_k;
	logic [1:0]  enc_phase;
	logic [1:0]  enc_pads;
	logic [2:0]  enc_n;

	logic [6:0]  dec_v;
	logic [11:0] dec_nb;
	logic [7:0]  dec_byte;
	logic        dec_has;

	always_comb begin
		enc_nb       = {buf_q[3:0], in_byte};
		enc_two      = 1'b0;
		enc_has_left = 1'b0;
		enc_left     = 6'd0;
		enc_c0       = enc_nb[7:2];
		buf_d        = {4'd0, enc_nb[1:0]};
		cnt_d        = 3'd2;
		case (cnt_q)
			3'd2: begin
				enc_c0   = enc_nb[9:4];
				buf_d    = {2'd0, enc_nb[3:0]};
				cnt_d    = 3'd4;
				enc_left = {enc_nb[3:0], 2'b00};
			end
			3'd4: begin
				enc_c0  = enc_nb[11:6];
				enc_two = 1'b1;
				buf_d   = 6'd0;
				cnt_d   = 3'd0;
			end
			default: begin
				enc_left = {enc_nb[1:0], 4'b0000};
			end
		endcase
		enc_has_left = in_last && !enc_two;
		enc_k        = enc_has_left || enc_two ? 2'd2 : 2'd1;
		enc_phase    = phase_q + enc_k;
		enc_pads     = in_last ? 2'(-enc_phase) : 2'd0;
		enc_n        = 3'(enc_k) + 3'(enc_pads);
		if (enc_n > 3'd4)
			enc_n = 3'd4;

		dec_v   = char_to_six(in_byte);
		dec_nb  = {buf_q, dec_v[5:0]};
		dec_has = 1'b1;
		dec_byte = 8'd0;

		pad_d   = pad_q;
		phase_d = phase_q;
		for (int i = 0; i < 4; i++) begin
			res[i] = '{data: CHAR_PAD, dvalid: 1'b1, last: 1'b0, bad: 1'b0};
		end

		if (direction == DIR_ENCODE) begin
			res[0].data = six_to_char(enc_c0);
			if (enc_two)
				res[1].data = six_to_char(enc_nb[5:0]);
			else if (enc_has_left)
				res[1].data = six_to_char(enc_left);
			n       = enc_n;
			phase_d = enc_phase;
		end else begin
			case (cnt_q)
				3'd2: begin
					dec_byte = dec_nb[7:0];
					buf_d    = 6'd0;
					cnt_d    = 3'd0;
				end
				3'd4: begin
					dec_byte = dec_nb[9:2];
					buf_d    = {4'd0, dec_nb[1:0]};
					cnt_d    = 3'd2;
				end
				3'd6: begin
					dec_byte = dec_nb[11:4];
					buf_d    = {2'd0, dec_nb[3:0]};
					cnt_d    = 3'd4;
				end
				default: begin
					dec_has = 1'b0;
					buf_d   = dec_nb[5:0];
					cnt_d   = 3'd6;
				end
			endcase
			res[0] = '{data: dec_byte, dvalid: 1'b1, last: 1'b0, bad: 1'b0};
			n      = {2'b00, dec_has};
			if (pad_q || in_byte == CHAR_PAD || dec_v[6]) begin
				buf_d = buf_q;
				cnt_d = cnt_q;
				n     = 3'd0;
			end
			if (!pad_q && in_byte == CHAR_PAD)
				pad_d = 1'b1;
			if (!pad_q && in_byte != CHAR_PAD && dec_v[6]) begin
				res[0] = '{data: 8'd0, dvalid: 1'b0, last: 1'b0, bad: 1'b1};
				n      = 3'd1;
			end
			if (in_last && n == 3'd0) begin
				res[0] = '{data: 8'd0, dvalid: 1'b0, last: 1'b0, bad: 1'b0};
				n      = 3'd1;
			end
		end

		for (int i = 0; i < 4; i++) begin
			res[i].last = in_last && (3'(i) == n - 3'd1);
		end

		push_job.res    = res;
		push_job.cnt_m1 = 2'(n - 3'd1);
		push            = accept && (n != 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q   <= 6'd0;
			cnt_q   <= 3'd0;
			phase_q <= 2'd0;
			pad_q   <= 1'b0;
		end else if (clear || (accept && in_last)) begin
			buf_q   <= 6'd0;
			cnt_q   <= 3'd0;
			phase_q <= 2'd0;
			pad_q   <= 1'b0;
		end else if (accept) begin
			buf_q   <= buf_d;
			cnt_q   <= cnt_d;
			phase_q <= phase_d;
			pad_q   <= pad_d;
		end
	end

endmodule

[sv/b64c_fifo.sv]
// ----------------------------------------------------------------------------
// b64c_fifo: two-entry job queue
// Decouples the intake side from the result side.
// ----------------------------------------------------------------------------
module b64c_fifo
	import b64c_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output job_t head_job,
	output logic empty
);

	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign head_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

endmodule

[sv/b64c_back.sv]
// ----------------------------------------------------------------------------
// b64c_back: result sequencer
// Walks the head job one result per cycle into the output register while res_ready allows.
// ----------------------------------------------------------------------------
module b64c_back
	import b64c_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  job_t head_job,
	input  logic empty,
	output logic pop,
	output logic res_valid,
	input  logic res_ready,
	output res_t res_out
);

	logic [1:0] idx_q;
	logic       vld_q;
	res_t       out_q;
	logic       load;

	assign load      = !vld_q || res_ready;
	assign pop       = load && !empty && (idx_q == head_job.cnt_m1);
	assign res_valid = vld_q;
	assign res_out   = out_q;

	always_ff @(posedge clk) begin
		if (load && !empty)
			out_q <= head_job.res[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= !empty;
			if (pop)
				idx_q <= 2'd0;
			else if (!empty)
				idx_q <= idx_q + 2'd1;
		end
	end

endmodule

[sv/base64_codec_unit.sv]
// ----------------------------------------------------------------------------
// base64_codec_unit: streaming base64 encoder/decoder
// Standard-alphabet codec with an APB direction register.
// ----------------------------------------------------------------------------
// One item is taken per cycle while the two-entry job queue has room; the
// output register hands out one result per cycle while res_ready is high,
// so the sustained rate is set by the result count: one or two characters
// per byte when encoding (two to four on the last byte), at most one result
// per character when decoding; a character that completes no byte yields
// none unless flagged bad or last. Results pass the job queue and then the
// output register. Writing the direction register clears the stream state.
module base64_codec_unit
	import b64c_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [APB_AW-1:0]   paddr,
	input  logic [APB_DW-1:0]   pwdata,
	output logic [APB_DW-1:0]   prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_byte,
	input  logic                in_last,
	output logic                res_valid,
	input  logic                res_ready,
	output logic [7:0]          out_byte,
	output logic                out_valid,
	output logic                out_last,
	output logic                bad_char
);

	logic direction_q;
	logic cfg_wr;
	logic accept;
	logic push;
	job_t push_job;
	logic full;
	logic pop;
	job_t head_job;
	logic empty;
	res_t res_out;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_DIRECTION);
	assign prdata = (paddr[2] == REG_DIRECTION) ? {{(APB_DW-1){1'b0}}, direction_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			direction_q <= DIR_ENCODE;
		else if (cfg_wr)
			direction_q <= pwdata[0];
	end

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	b64c_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.direction(direction_q),
		.clear    (cfg_wr),
		.accept   (accept),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.push     (push),
		.push_job (push_job)
	);

	b64c_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.pop      (pop),
		.head_job (head_job),
		.empty    (empty)
	);

	b64c_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_job (head_job),
		.empty    (empty),
		.pop      (pop),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_out  (res_out)
	);

	assign out_byte  = res_out.data;
	assign out_valid = res_out.dvalid;
	assign out_last  = res_out.last;
	assign bad_char  = res_out.bad;

	a_marker_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !out_valid && !bad_char |-> out_last)
		else $error("empty end marker without last flag");

	a_bad_is_empty: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && bad_char |-> !out_valid && out_byte == 8'd0)
		else $error("flagged character carries data");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty && !(res_valid && !res_ready))
		else $error("job retired while queue empty or output stalled");

endmodule

[tb/sv/tb_base64_codec_unit.sv]
// ----------------------------------------------------------------------------
// tb_base64_codec_unit: self-checking testbench for the base64 codec
// Drives byte and character streams in both directions through the valid/ready
// input, writes the direction register over APB while the stream is quiet, and
// compares every result with a cycle-free model of the encoder and decoder.
// ----------------------------------------------------------------------------
module tb_base64_codec_unit;
	import b64c_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_RESULTS    = 4;
	localparam int IDLE_SETTLE    = 8;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 3000;

	localparam logic [APB_AW-1:0] ADDR_DIRECTION = {REG_DIRECTION, 2'b00};
	localparam logic [APB_AW-1:0] ADDR_UNMAPPED  = 3'b100;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              psel      = 1'b0;
	logic              penable   = 1'b0;
	logic              pwrite    = 1'b0;
	logic [APB_AW-1:0] paddr     = '0;
	logic [APB_DW-1:0] pwdata    = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	logic [7:0]        in_byte   = '0;
	logic              in_last   = 1'b0;
	logic              res_valid;
	logic              res_ready = 1'b0;
	logic [7:0]        out_byte;
	logic              out_valid;
	logic              out_last;
	logic              bad_char;

	base64_codec_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.out_byte  (out_byte),
		.out_valid (out_valid),
		.out_last  (out_last),
		.bad_char  (bad_char)
	);

	always #5 clk = ~clk;

	// alphabet tables and codec model state
	logic [7:0]  alpha   [64];
	logic [6:0]  rev_tab [256];
	int unsigned acc_bits;
	int unsigned acc_cnt;
	int unsigned phase;
	bit          pad_flag;
	logic        dir_mode;

	res_t        item_results[$];
	res_t        expected_results[$];
	res_t        chk_exp;
	logic [7:0]  msg_buf[$];

	int  fail_count      = 0;
	int  items_sent      = 0;
	int  results_checked = 0;
	int  config_writes   = 0;
	int  enc_msgs        = 0;
	int  dec_msgs        = 0;
	int  quiet_cycles    = 0;
	bit  tx_gaps_on      = 1'b1;
	bit  rx_stalls_on    = 1'b1;
	bit  hold_request    = 1'b0;
	bit  rx_holding      = 1'b0;

	function void build_alphabet();
		for (int i = 0; i < 256; i++)
			rev_tab[8'(i)] = 7'd64;
		for (int i = 0; i < 26; i++) begin
			alpha[6'(i)]      = 8'("A" + i);
			alpha[6'(26 + i)] = 8'("a" + i);
		end
		for (int i = 0; i < 10; i++)
			alpha[6'(52 + i)] = 8'("0" + i);
		alpha[62] = "+";
		alpha[63] = "/";
		for (int i = 0; i < 64; i++)
			rev_tab[alpha[6'(i)]] = 7'(i);
	endfunction

	function void reset_stream_state();
		acc_bits = 0;
		acc_cnt  = 0;
		phase    = 0;
		pad_flag = 1'b0;
	endfunction

	function void add_result(logic [7:0] d, logic v, logic bad);
		res_t r;
		if (item_results.size() >= MAX_RESULTS)
			return;
		r.data   = d;
		r.dvalid = v;
		r.last   = 1'b0;
		r.bad    = bad;
		item_results.push_back(r);
	endfunction

	function void encode_byte(logic [7:0] b, logic lst);
		if (acc_cnt > 4)
			acc_cnt = 0;
		acc_bits = ((acc_bits << 8) | 32'(b)) & 32'hFFF;
		acc_cnt += 8;
		while (acc_cnt >= 6) begin
			acc_cnt -= 6;
			add_result(alpha[6'(acc_bits >> acc_cnt)], 1'b1, 1'b0);
			phase = (phase + 1) & 3;
			acc_bits &= (32'd1 << acc_cnt) - 32'd1;
		end
		if (!lst)
			return;
		if (acc_cnt != 0) begin
			add_result(alpha[6'(acc_bits << (6 - acc_cnt))], 1'b1, 1'b0);
			phase = (phase + 1) & 3;
			acc_bits = 0;
			acc_cnt = 0;
		end
		while (phase != 0) begin
			add_result(CHAR_PAD, 1'b1, 1'b0);
			phase = (phase + 1) & 3;
		end
	endfunction

	function void decode_char(logic [7:0] c);
		logic [6:0] six;
		if (pad_flag)
			return;
		if (c == CHAR_PAD) begin
			pad_flag = 1'b1;
			return;
		end
		six = rev_tab[c];
		if (six[6]) begin
			add_result(8'h00, 1'b0, 1'b1);
			return;
		end
		if (acc_cnt > 6)
			acc_cnt = 0;
		acc_bits = ((acc_bits << 6) | 32'(six[5:0])) & 32'hFFF;
		acc_cnt += 6;
		if (acc_cnt >= 8) begin
			acc_cnt -= 8;
			add_result(8'(acc_bits >> acc_cnt), 1'b1, 1'b0);
			acc_bits &= (32'd1 << acc_cnt) - 32'd1;
		end
	endfunction

	function void predict_codec(logic [7:0] b, logic lst);
		res_t r;
		item_results.delete();
		if (dir_mode == DIR_ENCODE)
			encode_byte(b, lst);
		else
			decode_char(b);
		if (lst) begin
			if (item_results.size() == 0)
				add_result(8'h00, 1'b0, 1'b0);
			r = item_results[item_results.size() - 1];
			r.last = 1'b1;
			item_results[item_results.size() - 1] = r;
			reset_stream_state();
		end
		foreach (item_results[i])
			expected_results.push_back(item_results[i]);
	endfunction

	function int pick_gap();
		int r;
		r = $urandom_range(0, 19);
		if (r < 12)
			return 0;
		if (r < 18)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function void randomize_idling();
		tx_gaps_on   = ($urandom_range(0, 3) != 0);
		rx_stalls_on = ($urandom_range(0, 3) != 0);
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			results_checked++;
			if (expected_results.size() == 0) begin
				$error("unexpected result: out_byte %02h out_valid %0b out_last %0b bad_char %0b",
					out_byte, out_valid, out_last, bad_char);
				fail_count++;
			end else begin
				chk_exp = expected_results.pop_front();
				if (out_byte !== chk_exp.data) begin
					$error("out_byte: expected %02h, got %02h", chk_exp.data, out_byte);
					fail_count++;
				end
				if (out_valid !== chk_exp.dvalid) begin
					$error("out_valid: expected %0b, got %0b", chk_exp.dvalid, out_valid);
					fail_count++;
				end
				if (out_last !== chk_exp.last) begin
					$error("out_last: expected %0b, got %0b", chk_exp.last, out_last);
					fail_count++;
				end
				if (bad_char !== chk_exp.bad) begin
					$error("bad_char: expected %0b, got %0b", chk_exp.bad, bad_char);
					fail_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (res_valid && res_ready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("base64_codec_unit: mismatch");
			$finish;
		end
	end

	// result receiver
	initial begin : receiver
		int burst;
		int gap;
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				rx_holding   = 1'b1;
				res_ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				rx_holding = 1'b0;
			end
			res_ready <= 1'b1;
			burst = $urandom_range(1, 12);
			repeat (burst) @(posedge clk);
			gap = rx_stalls_on ? pick_gap() : 0;
			if (gap > 0) begin
				res_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	task send_item(input logic [7:0] b, input logic lst);
		int gap;
		in_valid <= 1'b1;
		in_byte  <= b;
		in_last  <= lst;
		do @(posedge clk); while (!in_ready);
		predict_codec(b, lst);
		items_sent++;
		gap = tx_gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task send_msg_buf();
		for (int i = 0; i < msg_buf.size(); i++)
			send_item(msg_buf[i], i == msg_buf.size() - 1);
	endtask

	task wait_idle();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (IDLE_SETTLE) @(posedge clk);
	endtask

	task reg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr[APB_AW-1:2] == REG_DIRECTION) begin
			dir_mode = data[0];
			reset_stream_state();
		end
		config_writes++;
	endtask

	task reg_check(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] want);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== want) begin
			$error("prdata: expected %08h, got %08h", want, prdata);
			fail_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task test_encode_directed();
		wait_idle();
		reg_write(ADDR_DIRECTION, 32'(DIR_ENCODE));
		msg_buf = '{8'h4D, 8'h61, 8'h6E};
		send_msg_buf();
		msg_buf = '{8'hFB, 8'hFF, 8'hFF};
		send_msg_buf();
		msg_buf = '{8'h00};
		send_msg_buf();
		msg_buf = '{8'hFF};
		send_msg_buf();
		msg_buf = '{8'h12, 8'h34};
		send_msg_buf();
		enc_msgs += 5;
		wait_idle();
	endtask

	task test_decode_directed();
		reg_write(ADDR_DIRECTION, 32'(DIR_DECODE));
		reg_check(ADDR_DIRECTION, 32'(DIR_DECODE));
		msg_buf = '{"T", "W", "F", "u"};
		send_msg_buf();
		msg_buf = '{"/", "w", "=", "="};
		send_msg_buf();
		msg_buf = '{"z", 8'h20, "0", "9", 8'hFF};
		send_msg_buf();
		dec_msgs += 3;
		wait_idle();
	endtask

	task test_register_writes();
		reg_write(ADDR_DIRECTION, 32'(DIR_ENCODE));
		reg_check(ADDR_DIRECTION, 32'(DIR_ENCODE));
		send_item(8'h4D, 1'b0);
		wait_idle();
		reg_write(ADDR_UNMAPPED, 32'hFFFF_FFFF);
		send_item(8'h61, 1'b0);
		send_item(8'h6E, 1'b1);
		send_item(8'hAB, 1'b0);
		wait_idle();
		reg_write(ADDR_DIRECTION, 32'hFFFF_FFFF);
		reg_check(ADDR_DIRECTION, 32'(DIR_DECODE));
		send_item("Q", 1'b0);
		wait_idle();
		reg_write(ADDR_DIRECTION, 32'(DIR_DECODE));
		send_item("Q", 1'b0);
		send_item("Q", 1'b1);
		wait_idle();
		reg_write(ADDR_DIRECTION, 32'hFFFF_FFFE);
		reg_check(ADDR_DIRECTION, 32'(DIR_ENCODE));
		enc_msgs += 2;
		dec_msgs += 1;
	endtask

	task test_output_backpressure();
		wait_idle();
		reg_write(ADDR_DIRECTION, 32'(DIR_ENCODE));
		tx_gaps_on = 1'b0;
		hold_request = 1'b1;
		while (!rx_holding)
			@(posedge clk);
		msg_buf.delete();
		repeat (30) msg_buf.push_back(8'($urandom_range(0, 255)));
		send_msg_buf();
		enc_msgs++;
		wait_idle();
	endtask

	task test_random_encode(input int n_items);
		int start;
		int len;
		wait_idle();
		reg_write(ADDR_DIRECTION, 32'(DIR_ENCODE));
		start = items_sent;
		while (items_sent - start < n_items) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
			msg_buf.delete();
			repeat (len) msg_buf.push_back(8'($urandom_range(0, 255)));
			randomize_idling();
			send_msg_buf();
			enc_msgs++;
		end
		wait_idle();
	endtask

	task build_decode_msg();
		int kind;
		int n;
		kind = $urandom_range(0, 9);
		msg_buf.delete();
		if (kind == 0) begin
			n = $urandom_range(1, 8);
			repeat (n) msg_buf.push_back(8'($urandom_range(0, 255)));
			return;
		end
		n = 4 * $urandom_range(1, 4);
		repeat (n) msg_buf.push_back(alpha[6'($urandom_range(0, 63))]);
		case ($urandom_range(0, 2))
			1: msg_buf[n - 1] = CHAR_PAD;
			2: begin
				msg_buf[n - 1] = CHAR_PAD;
				msg_buf[n - 2] = CHAR_PAD;
			end
			default: ;
		endcase
		if (kind == 1) begin
			repeat ($urandom_range(1, 3))
				msg_buf[$urandom_range(0, n - 1)] = 8'($urandom_range(0, 255));
		end else if (kind == 2) begin
			msg_buf.push_back(CHAR_PAD);
			repeat ($urandom_range(1, 3)) msg_buf.push_back(8'($urandom_range(0, 255)));
		end else if (kind == 3) begin
			void'(msg_buf.pop_back());
		end
	endtask

	task test_random_decode(input int n_items);
		int start;
		wait_idle();
		reg_write(ADDR_DIRECTION, 32'(DIR_DECODE));
		start = items_sent;
		while (items_sent - start < n_items) begin
			build_decode_msg();
			randomize_idling();
			send_msg_buf();
			dec_msgs++;
		end
		wait_idle();
	endtask

	initial begin
		build_alphabet();
		dir_mode = DIR_ENCODE;
		reset_stream_state();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_encode_directed();
		test_decode_directed();
		test_register_writes();
		test_output_backpressure();
		test_random_encode(160);
		test_random_decode(95);
		test_random_decode(95);
		tx_gaps_on   = 1'b1;
		rx_stalls_on = 1'b1;
		wait_idle();

		$display("run covered %0d input transactions and %0d result transactions",
			items_sent, results_checked);
		$display("%0d encode and %0d decode messages across %0d register writes",
			enc_msgs, dec_msgs, config_writes);
		if (fail_count == 0)
			$display("base64_codec_unit: match");
		else
			$display("base64_codec_unit: mismatch");
		$finish;
	end

endmodule
